/* hdl/ced_pkg.sv */
`timescale 1ns / 1ps

package ced_pkg;

	// Width of the decoded length counter; the count saturates at 2^LENGTH_BITS-1, and at 65535
	localparam int LENGTH_BITS = 16;
	localparam logic [15:0] COUNT_LIMIT = (LENGTH_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << LENGTH_BITS) - 32'd1);

	// Result pairs held between the front and the back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

	// One request's worth of results: up to two decoded bytes
	typedef struct packed {
		logic [7:0] val0;
		logic       pres0;
		logic [7:0] val1;
		logic       pres1;
		logic       two;    // second result is present
		logic       last;   // closes the string
	} pair_t;

endpackage

/* hdl/ced_front.sv */
`timescale 1ns / 1ps

module ced_front import ced_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       ent_valid,
	output pair_t      ent
);

	typedef enum logic [3:0] {
		MODE_PLAIN = 4'b0001,
		MODE_ESC   = 4'b0010,
		MODE_OCT   = 4'b0100,
		MODE_HEX   = 4'b1000
	} mode_t;

	mode_t      mode_q, mode_d;
	logic [7:0] num_q, num_d;
	logic [1:0] dig_q, dig_d;

	logic       is_bs, is_oct, is_hex;
	logic [3:0] hex_d;
	logic       map_hit;
	logic [7:0] map_val;
	logic [1:0] dig_inc;
	pair_t      e;

	// Character classes
	always_comb begin
		is_bs  = (in_byte == CHAR_BACKSLASH);
		is_oct = (in_byte[7:3] == 5'b00110);
		is_hex = 1'b0;
		hex_d  = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			is_hex = 1'b1;
			hex_d  = in_byte[3:0];
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
			(in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			is_hex = 1'b1;
			hex_d  = in_byte[3:0] + 4'd9;
		end
	end

	// Named control escapes
	always_comb begin
		map_hit = 1'b1;
		map_val = 8'd0;
		unique case (in_byte)
			8'h61:   map_val = 8'd7;   // a
			8'h62:   map_val = 8'd8;   // b
			8'h65:   map_val = 8'd27;  // e
			8'h66:   map_val = 8'd12;  // f
			8'h6E:   map_val = 8'd10;  // n
			8'h72:   map_val = 8'd13;  // r
			8'h74:   map_val = 8'd9;   // t
			8'h76:   map_val = 8'd11;  // v
			default: map_hit = 1'b0;
		endcase
	end

	assign dig_inc = dig_q + 2'd1;

	// Decode step: next state and the results of this request
	always_comb begin
		mode_d = mode_q;
		num_d  = num_q;
		dig_d  = dig_q;
		e      = '0;
		e.last = in_last;
		unique case (mode_q)
			MODE_PLAIN: begin
				if (is_bs) begin
					mode_d = MODE_ESC;
				end else begin
					e.pres0 = 1'b1;
					e.val0  = in_byte;
				end
			end
			MODE_ESC: begin
				mode_d = MODE_PLAIN;
				if (map_hit) begin
					e.pres0 = 1'b1;
					e.val0  = map_val;
				end else if (in_byte == 8'h78) begin
					mode_d = MODE_HEX;
					num_d  = 8'd0;
					dig_d  = 2'd0;
				end else if (is_oct) begin
					mode_d = MODE_OCT;
					num_d  = {5'd0, in_byte[2:0]};
					dig_d  = 2'd1;
				end else begin
					e.pres0 = 1'b1;
					e.val0  = in_byte;
				end
			end
			MODE_OCT, MODE_HEX: begin
				if ((mode_q == MODE_OCT && is_oct) || (mode_q == MODE_HEX && is_hex)) begin
					num_d = (mode_q == MODE_OCT) ? {num_q[4:0], in_byte[2:0]} :
						{num_q[3:0], hex_d};
					dig_d = dig_inc;
					// full number goes out at once
					if ((mode_q == MODE_OCT && dig_inc == 2'd3) ||
						(mode_q == MODE_HEX && dig_inc == 2'd2)) begin
						e.pres0 = 1'b1;
						e.val0  = num_d;
						mode_d  = MODE_PLAIN;
					end
				end else begin
					// number ended by next byte: plain text, or a backslash escape
					e.pres0 = 1'b1;
					e.val0  = num_q;
					mode_d  = MODE_PLAIN;
					if (is_bs) begin
						mode_d = MODE_ESC;
					end else begin
						e.pres1 = 1'b1;
						e.val1  = in_byte;
						e.two   = 1'b1;
					end
				end
			end
			default: mode_d = MODE_PLAIN;
		endcase
		// pending number flushed at string end
		if (in_last && (mode_d == MODE_OCT || mode_d == MODE_HEX)) begin
			e.pres0 = 1'b1;
			e.val0  = num_d;
		end
	end

	assign ent       = e;
	assign ent_valid = e.pres0 | in_last;

	// Decode state; a closed string returns to plain text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			num_q  <= 8'd0;
			dig_q  <= 2'd0;
		end else if (take) begin
			if (in_last) begin
				mode_q <= MODE_PLAIN;
				num_q  <= 8'd0;
				dig_q  <= 2'd0;
			end else begin
				mode_q <= mode_d;
				num_q  <= num_d;
				dig_q  <= dig_d;
			end
		end
	end

endmodule

/* hdl/ced_queue.sv */
`timescale 1ns / 1ps

module ced_queue import ced_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  pair_t wr_data,
	input  logic  rd,
	output pair_t rd_data,
	output logic  q_full,
	output logic  q_empty
);

	pair_t                slots_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [QCNT_BITS-1:0] cnt_q;

	assign q_full  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = slots_q[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr) begin
			slots_q[wptr_q] <= wr_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/ced_back.sv */
`timescale 1ns / 1ps

module ced_back import ced_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  pair_t       head,
	output logic        q_rd,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        byte_present,
	output logic        string_end,
	output logic [15:0] out_length,
	output logic        run_last
);

	logic        slot_q;
	logic [15:0] count_q;
	logic        taken;

	assign empty = q_empty;
	assign taken = pop & ~q_empty;

	// Present the selected half of the head pair
	always_comb begin
		if (slot_q) begin
			out_byte     = head.val1;
			byte_present = head.pres1;
			run_last     = 1'b1;
			string_end   = head.last;
		end else begin
			out_byte     = head.val0;
			byte_present = head.pres0;
			run_last     = ~head.two;
			string_end   = head.last & ~head.two;
		end
		out_length = (byte_present && count_q != COUNT_LIMIT) ? count_q + 16'd1 : count_q;
	end

	// Head pair leaves once its final result is taken
	assign q_rd = taken & run_last;

	// Result slot and running length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= 1'b0;
			count_q <= 16'd0;
		end else if (taken) begin
			slot_q  <= ~run_last;
			count_q <= string_end ? 16'd0 : out_length;
		end
	end

endmodule

/* hdl/c_escape_sequence_decoder_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Request moves when   Ports
// input     in         push & !full         in_byte, in_last
// result    out        pop & !empty         out_byte, byte_present, string_end,
//                                            out_length, run_last
//
// One input request is taken per cycle while the pair queue has room; its results
// are written to the pair queue and reach the result ports behind any earlier entries.
// Results leave at one per cycle; a request that yields two results holds its queue
// entry for two pops, so sustained input rate with back-pressure-free output is
// set by the single result port.
// Reset clears decode state, queue pointers and the length count; no clearing pass.
// A stalled result side fills the four-entry pair queue, then full rises.

module c_escape_sequence_decoder_unit import ced_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        byte_present,
	output logic        string_end,
	output logic [15:0] out_length,
	output logic        run_last
);

	logic  take, ent_valid, q_rd, q_empty;
	pair_t ent, head;

	assign take = push & ~full;

	// Front: classify and decode
	ced_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.ent_valid (ent_valid),
		.ent       (ent)
	);

	// Pair queue between the two sides
	ced_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take & ent_valid),
		.wr_data (ent),
		.rd      (q_rd),
		.rd_data (head),
		.q_full  (full),
		.q_empty (q_empty)
	);

	// Back: serialise results and count length
	ced_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (head),
		.q_rd         (q_rd),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.string_end   (string_end),
		.out_length   (out_length),
		.run_last     (run_last)
	);

endmodule

/* hdl/ced_checker.sv */
`timescale 1ns / 1ps

module ced_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [7:0]  in_byte,
	input logic        in_last,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  out_byte,
	input logic        byte_present,
	input logic        string_end,
	input logic [15:0] out_length,
	input logic        run_last
);

	// String close is always the final result of its request
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && string_end |-> run_last)
		else $error("string_end without run_last");

	// A result without a byte only closes a string, and carries zero
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !byte_present |-> string_end && out_byte == 8'd0)
		else $error("byte-less result not a clean close");

	// Second result of a request follows straight on
	a_pair_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !run_last |=> !empty)
		else $error("second result lost");

	// Length restarts after a string close
	a_len_restart: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!empty && pop && string_end) && !empty |-> out_length <= 16'd1)
		else $error("length not restarted");

endmodule

bind c_escape_sequence_decoder_unit ced_checker u_ced_checker (.*);
